FILE: rtl/hvcd_pkg.sv
// ============================================================================
// hvcd_pkg
// Shared types and constants of the hashed voxel centroid downsampler.
// ============================================================================
package hvcd_pkg;

    localparam int unsigned HASH_KX = 7171;
    localparam int unsigned HASH_KY = 3079;
    localparam int unsigned HASH_KZ = 4231;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // configuration register indexes
    localparam logic [1:0] REG_INV_X = 2'd0;
    localparam logic [1:0] REG_INV_Y = 2'd1;
    localparam logic [1:0] REG_INV_Z = 2'd2;
    localparam logic [1:0] REG_COLOR = 2'd3;

    localparam logic FUNC_ACCUM = 1'b0;
    localparam logic FUNC_DRAIN = 1'b1;

    // bin record as stored in the bin memory
    typedef struct packed {
        logic [15:0]        count;
        logic signed [15:0] vox_x;
        logic signed [15:0] vox_y;
        logic signed [15:0] vox_z;
        logic signed [47:0] sum_x;
        logic signed [47:0] sum_y;
        logic signed [47:0] sum_z;
        logic [23:0]        sum_r;
        logic [23:0]        sum_g;
        logic [23:0]        sum_b;
    } bin_rec_t;

    localparam int BIN_W = $bits(bin_rec_t);

    // request to the centroid divider
    typedef struct packed {
        logic               start;
        logic               color;
        bin_rec_t           rec;
    } div_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IDX,
        ST_HASH,
        ST_READ,
        ST_UPDATE,
        ST_WAIT_DIV,
        ST_CLEAR
    } ctrl_state_t;

endpackage

FILE: rtl/hashed_voxel_centroid_downsampler.sv
// ============================================================================
// hashed_voxel_centroid_downsampler
// Approximate voxel grid filter over a direct-mapped bin memory.
// ============================================================================
// A point item holds busy through the index multiply, hash, memory read and
// update states, so the next item is accepted only after it is back in idle;
// an item that evicts or drains an occupied bin holds busy on while the
// bit-serial centroid divider (one quotient bit per cycle, 48 bits) finishes,
// and the result strobes out on done. The receiver cannot stall: done is
// high for one cycle only. After reset the bin memory is cleared one bin
// per cycle, every bin in turn, with busy high.
module hashed_voxel_centroid_downsampler
    import hvcd_pkg::*;
#(
    parameter int HIST_SIZE = 512
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               func,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic [8:0]         bin_index,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               done,
    output logic signed [31:0] centroid_x,
    output logic signed [31:0] centroid_y,
    output logic signed [31:0] centroid_z,
    output logic [7:0]         mean_red,
    output logic [7:0]         mean_green,
    output logic [7:0]         mean_blue,
    output logic [15:0]        point_count,
    output logic signed [15:0] voxel_x,
    output logic signed [15:0] voxel_y,
    output logic signed [15:0] voxel_z
);

    localparam int AW = $clog2(HIST_SIZE);

    ctrl_state_t state_reg, state_next;

    logic [31:0] inv_x_reg, inv_y_reg, inv_z_reg;
    logic        color_reg;

    logic              func_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [7:0]        r_reg, g_reg, b_reg;
    logic [AW-1:0]     addr_reg, addr_next;
    logic signed [63:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [15:0] ix_reg, iy_reg, iz_reg;
    logic [AW-1:0]     clr_reg;

    logic              we;
    logic [AW-1:0]     ram_addr;
    bin_rec_t          wrec, rrec, fresh;
    div_req_t          dreq;
    logic              dbusy;

    // saturate the high word of a product to 16 bits
    function automatic logic signed [15:0] sat16(input logic signed [63:0] p);
        logic signed [31:0] q;
        q = p[63:32];
        if (q > 32'sd32767)
        begin
            sat16 = 16'sh7FFF;
        end
        else if (q < -32'sd32768)
        begin
            sat16 = 16'sh8000;
        end
        else
        begin
            sat16 = q[15:0];
        end
    endfunction

    // configuration writes
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_x_reg <= 32'd6553600;
            inv_y_reg <= 32'd6553600;
            inv_z_reg <= 32'd6553600;
            color_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_INV_X: inv_x_reg <= cfg_data;
                REG_INV_Y: inv_y_reg <= cfg_data;
                REG_INV_Z: inv_z_reg <= cfg_data;
                REG_COLOR: color_reg <= cfg_data[0];
                default:   ;
            endcase
        end
    end

    // state register and clear counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    // capture the item and run the index datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            func_reg <= func;
            px_reg   <= pos_x;
            py_reg   <= pos_y;
            pz_reg   <= pos_z;
            r_reg    <= red;
            g_reg    <= green;
            b_reg    <= blue;
            addr_reg <= AW'(bin_index);
        end
        if (state_reg == ST_IDX)
        begin
            prod_x_reg <= px_reg * $signed({1'b0, inv_x_reg});
            prod_y_reg <= py_reg * $signed({1'b0, inv_y_reg});
            prod_z_reg <= pz_reg * $signed({1'b0, inv_z_reg});
        end
        if (state_reg == ST_HASH)
        begin
            ix_reg   <= sat16(prod_x_reg);
            iy_reg   <= sat16(prod_y_reg);
            iz_reg   <= sat16(prod_z_reg);
            addr_reg <= addr_next;
        end
    end

    // hash of the saturated indices, or the given bin index on a drain
    always_comb
    begin
        logic [31:0] h;
        h = 32'($signed(sat16(prod_x_reg))) * HASH_KX
          + 32'($signed(sat16(prod_y_reg))) * HASH_KY
          + 32'($signed(sat16(prod_z_reg))) * HASH_KZ;
        addr_next = func_reg ? addr_reg : h[AW-1:0];
    end

    // bin memory
    hvcd_ram #(.WIDTH(BIN_W), .DEPTH(HIST_SIZE)) u_bins (
        .clk   (clk),
        .we    (we),
        .addr  (ram_addr),
        .wdata (wrec),
        .rdata (rrec)
    );

    // control: clear after reset, read, modify, write back, launch the divider
    always_comb
    begin
        logic evict;
        state_next = state_reg;
        we         = 1'b0;
        ram_addr   = addr_reg;
        wrec       = '0;
        dreq       = '0;
        dreq.color = color_reg;
        dreq.rec   = rrec;
        fresh      = '0;
        evict      = 1'b0;
        fresh.count = 16'd1;
        fresh.vox_x = ix_reg;
        fresh.vox_y = iy_reg;
        fresh.vox_z = iz_reg;
        fresh.sum_x = 48'(px_reg);
        fresh.sum_y = 48'(py_reg);
        fresh.sum_z = 48'(pz_reg);
        if (color_reg)
        begin
            fresh.sum_r = 24'(r_reg);
            fresh.sum_g = 24'(g_reg);
            fresh.sum_b = 24'(b_reg);
        end
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_addr = clr_reg;
                we = 1'b1;
                if (clr_reg == AW'(HIST_SIZE - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_IDX;
                end
            end
            ST_IDX:    state_next = ST_HASH;
            ST_HASH:   state_next = ST_READ;
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                we = 1'b1;
                if (func_reg == FUNC_DRAIN)
                begin
                    evict = rrec.count != '0;
                end
                else if (rrec.count != '0 &&
                         (rrec.vox_x != ix_reg || rrec.vox_y != iy_reg ||
                          rrec.vox_z != iz_reg || rrec.count == COUNT_MAX))
                begin
                    evict = 1'b1;
                    wrec  = fresh;
                end
                else
                begin
                    wrec = rrec;
                    wrec.vox_x = ix_reg;
                    wrec.vox_y = iy_reg;
                    wrec.vox_z = iz_reg;
                    wrec.count = rrec.count + 16'd1;
                    wrec.sum_x = rrec.sum_x + fresh.sum_x;
                    wrec.sum_y = rrec.sum_y + fresh.sum_y;
                    wrec.sum_z = rrec.sum_z + fresh.sum_z;
                    wrec.sum_r = rrec.sum_r + fresh.sum_r;
                    wrec.sum_g = rrec.sum_g + fresh.sum_g;
                    wrec.sum_b = rrec.sum_b + fresh.sum_b;
                end
                dreq.start = evict;
                state_next = evict ? ST_WAIT_DIV : ST_IDLE;
            end
            ST_WAIT_DIV:
            begin
                if (done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    hvcd_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .busy  (dbusy),
        .done  (done),
        .cx    (centroid_x),
        .cy    (centroid_y),
        .cz    (centroid_z),
        .mr    (mean_red),
        .mg    (mean_green),
        .mb    (mean_blue),
        .cnt   (point_count),
        .vx    (voxel_x),
        .vy    (voxel_y),
        .vz    (voxel_z)
    );

    assign busy = state_reg != ST_IDLE;

    // the divider only runs while the controller waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        dbusy |-> state_reg == ST_WAIT_DIV)
        else $error("divider running outside wait state");

    // a result never appears with an empty bin
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> point_count != '0)
        else $error("result with zero count");

    // no item accepted while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result strobe while idle");

endmodule

FILE: rtl/hvcd_ram.sv
// ============================================================================
// hvcd_ram
// Generic single-port synchronous RAM with registered read.
// ============================================================================
module hvcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write, and register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/hvcd_divider.sv
// ============================================================================
// hvcd_divider
// Centroid divider: divides all six sums by the count, one quotient bit per
// cycle per lane, with shared restoring steps.
// ============================================================================
module hvcd_divider
    import hvcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_req_t           req,
    output logic               busy,
    output logic               done,
    output logic signed [31:0] cx,
    output logic signed [31:0] cy,
    output logic signed [31:0] cz,
    output logic [7:0]         mr,
    output logic [7:0]         mg,
    output logic [7:0]         mb,
    output logic [15:0]        cnt,
    output logic signed [15:0] vx,
    output logic signed [15:0] vy,
    output logic signed [15:0] vz
);

    localparam int NL = 6;
    localparam int DW = 48;

    logic [5:0]        step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic              color_reg;
    logic [15:0]       den_reg;
    logic [NL-1:0]     neg_reg;
    logic [DW-1:0]     num_reg [NL];
    logic [15:0]       rem_reg [NL];
    logic signed [15:0] vx_reg, vy_reg, vz_reg;

    logic [DW-1:0]     mag_in [NL];
    logic [16:0]       trial [NL];

    // magnitudes of the sums at start, and each lane's trial subtraction
    always_comb
    begin
        mag_in[0] = req.rec.sum_x[47] ? DW'(-req.rec.sum_x) : DW'(req.rec.sum_x);
        mag_in[1] = req.rec.sum_y[47] ? DW'(-req.rec.sum_y) : DW'(req.rec.sum_y);
        mag_in[2] = req.rec.sum_z[47] ? DW'(-req.rec.sum_z) : DW'(req.rec.sum_z);
        mag_in[3] = DW'(req.rec.sum_r);
        mag_in[4] = DW'(req.rec.sum_g);
        mag_in[5] = DW'(req.rec.sum_b);
        for (int i = 0; i < NL; i++)
        begin
            trial[i] = {rem_reg[i], num_reg[i][DW-1]} - {1'b0, den_reg};
        end
    end

    // iterate one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                step_reg <= 6'(DW - 1);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 6'd1;
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            color_reg <= req.color;
            den_reg   <= req.rec.count;
            vx_reg    <= req.rec.vox_x;
            vy_reg    <= req.rec.vox_y;
            vz_reg    <= req.rec.vox_z;
            neg_reg   <= {3'b000, req.rec.sum_z[47], req.rec.sum_y[47], req.rec.sum_x[47]};
            for (int i = 0; i < NL; i++)
            begin
                num_reg[i] <= mag_in[i];
                rem_reg[i] <= '0;
            end
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < NL; i++)
            begin
                if (!trial[i][16])
                begin
                    rem_reg[i] <= trial[i][15:0];
                    num_reg[i] <= {num_reg[i][DW-2:0], 1'b1};
                end
                else
                begin
                    // shifted remainder is below the count here, so it fits 16 bits
                    rem_reg[i] <= {rem_reg[i][14:0], num_reg[i][DW-1]};
                    num_reg[i] <= {num_reg[i][DW-2:0], 1'b0};
                end
            end
        end
    end

    // apply signs and truncate
    assign cx   = neg_reg[0] ? 32'(-num_reg[0]) : 32'(num_reg[0]);
    assign cy   = neg_reg[1] ? 32'(-num_reg[1]) : 32'(num_reg[1]);
    assign cz   = neg_reg[2] ? 32'(-num_reg[2]) : 32'(num_reg[2]);
    assign mr   = color_reg ? num_reg[3][7:0] : 8'd0;
    assign mg   = color_reg ? num_reg[4][7:0] : 8'd0;
    assign mb   = color_reg ? num_reg[5][7:0] : 8'd0;
    assign cnt  = den_reg;
    assign vx   = vx_reg;
    assign vy   = vy_reg;
    assign vz   = vz_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

FILE: tb/hashed_voxel_centroid_downsampler_test.sv
`timescale 1ns / 1ps
// ============================================================================
// hashed_voxel_centroid_downsampler_test
// Self-checking bench for the voxel centroid downsampler. A bin-table
// tracker predicts every centroid from the accepted points, drains and
// register writes, and compares each done strobe field by field.
// Directed points, drains and register writes come first. Random clustered
// point streams follow under several leaf sizes, and a sweep drains every bin.
// ============================================================================
module hashed_voxel_centroid_downsampler_test;
    import hvcd_pkg::*;

    localparam int NUM_BINS   = 512;
    localparam int STALL_MAX  = 3000;

    typedef struct {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [7:0]         mr;
        logic [7:0]         mg;
        logic [7:0]         mb;
        logic [15:0]        cnt;
        logic signed [15:0] vx;
        logic signed [15:0] vy;
        logic signed [15:0] vz;
    } centroid_t;

    // ------------------------------------------------------------------------
    // Bin table tracker: mirrors the bin memory and queues predicted centroids
    // ------------------------------------------------------------------------
    class voxel_bin_tracker;
        logic [31:0]        inv_x = 32'd6553600;
        logic [31:0]        inv_y = 32'd6553600;
        logic [31:0]        inv_z = 32'd6553600;
        bit                 color_on = 1'b0;
        int unsigned        occupancy [NUM_BINS];
        logic signed [15:0] tag_x [NUM_BINS];
        logic signed [15:0] tag_y [NUM_BINS];
        logic signed [15:0] tag_z [NUM_BINS];
        longint             sum_x [NUM_BINS];
        longint             sum_y [NUM_BINS];
        longint             sum_z [NUM_BINS];
        int unsigned        sum_r [NUM_BINS];
        int unsigned        sum_g [NUM_BINS];
        int unsigned        sum_b [NUM_BINS];
        centroid_t          pending_centroids [$];
        int                 errors = 0;
        int                 centroids_seen = 0;
        int                 points_seen = 0;
        int                 drains_seen = 0;

        function new();
            foreach (occupancy[k])
                wipe(k);
        endfunction

        function void wipe(int k);
            occupancy[k] = 0;
            tag_x[k] = '0; tag_y[k] = '0; tag_z[k] = '0;
            sum_x[k] = 0; sum_y[k] = 0; sum_z[k] = 0;
            sum_r[k] = 0; sum_g[k] = 0; sum_b[k] = 0;
        endfunction

        // append a predicted centroid to the expected list
        function void queue_centroid(centroid_t c);
            pending_centroids.insert(pending_centroids.size(), c);
        endfunction

        task report(string msg);
            errors++;
            $display("%0t MISMATCH: %s", $realtime, msg);
        endtask

        function void note_config(logic [1:0] idx, logic [31:0] data);
            case (idx)
                REG_INV_X: inv_x = data;
                REG_INV_Y: inv_y = data;
                REG_INV_Z: inv_z = data;
                REG_COLOR: color_on = data[0];
                default: ;
            endcase
        endfunction

        // floor(pos * inv / 2**32) from the exact product, saturated to 16 bits
        function logic signed [15:0] voxel_of(logic signed [31:0] pos, logic [31:0] inv);
            logic signed [63:0] prod;
            logic signed [63:0] q;
            prod = 64'(pos) * $signed({32'd0, inv});
            q = prod >>> 32;
            if (q > 64'sd32767)
                return 16'sh7FFF;
            if (q < -64'sd32768)
                return 16'sh8000;
            return q[15:0];
        endfunction

        function centroid_t centroid_of(int k);
            centroid_t c;
            longint n;
            longint qx, qy, qz;
            n = longint'(occupancy[k]);
            qx = sum_x[k] / n;
            qy = sum_y[k] / n;
            qz = sum_z[k] / n;
            c.cx = qx[31:0];
            c.cy = qy[31:0];
            c.cz = qz[31:0];
            c.mr = color_on ? 8'(sum_r[k] / occupancy[k]) : 8'd0;
            c.mg = color_on ? 8'(sum_g[k] / occupancy[k]) : 8'd0;
            c.mb = color_on ? 8'(sum_b[k] / occupancy[k]) : 8'd0;
            c.cnt = occupancy[k][15:0];
            c.vx = tag_x[k];
            c.vy = tag_y[k];
            c.vz = tag_z[k];
            return c;
        endfunction

        function void note_item(logic f, logic signed [31:0] px, logic signed [31:0] py,
                                logic signed [31:0] pz, logic [7:0] r, logic [7:0] g,
                                logic [7:0] b, logic [8:0] bi);
            logic signed [15:0] ix, iy, iz;
            logic [31:0] h;
            int k;
            if (f == FUNC_DRAIN)
            begin
                drains_seen++;
                k = int'(bi) & (NUM_BINS - 1);
                if (occupancy[k] != 0)
                    queue_centroid(centroid_of(k));
                wipe(k);
                return;
            end
            points_seen++;
            ix = voxel_of(px, inv_x);
            iy = voxel_of(py, inv_y);
            iz = voxel_of(pz, inv_z);
            h = 32'(ix) * HASH_KX + 32'(iy) * HASH_KY + 32'(iz) * HASH_KZ;
            k = int'(h) & (NUM_BINS - 1);
            // evict on a foreign voxel or a full count
            if (occupancy[k] != 0 && (tag_x[k] != ix || tag_y[k] != iy || tag_z[k] != iz ||
                                      occupancy[k] >= int'(COUNT_MAX)))
            begin
                queue_centroid(centroid_of(k));
                wipe(k);
            end
            tag_x[k] = ix; tag_y[k] = iy; tag_z[k] = iz;
            occupancy[k]++;
            sum_x[k] += longint'(px);
            sum_y[k] += longint'(py);
            sum_z[k] += longint'(pz);
            if (color_on)
            begin
                sum_r[k] += r;
                sum_g[k] += g;
                sum_b[k] += b;
            end
        endfunction

        task check_centroid(centroid_t got);
            centroid_t want;
            string diff;
            if (pending_centroids.size() == 0)
            begin
                report($sformatf("unexpected centroid count=%0d voxel=(%0d,%0d,%0d)",
                                 got.cnt, got.vx, got.vy, got.vz));
                return;
            end
            want = pending_centroids.pop_front();
            centroids_seen++;
            diff = "";
            if (got.cx !== want.cx) diff = {diff, $sformatf(" cx %h/%h", got.cx, want.cx)};
            if (got.cy !== want.cy) diff = {diff, $sformatf(" cy %h/%h", got.cy, want.cy)};
            if (got.cz !== want.cz) diff = {diff, $sformatf(" cz %h/%h", got.cz, want.cz)};
            if (got.mr !== want.mr) diff = {diff, $sformatf(" r %h/%h", got.mr, want.mr)};
            if (got.mg !== want.mg) diff = {diff, $sformatf(" g %h/%h", got.mg, want.mg)};
            if (got.mb !== want.mb) diff = {diff, $sformatf(" b %h/%h", got.mb, want.mb)};
            if (got.cnt !== want.cnt) diff = {diff, $sformatf(" n %h/%h", got.cnt, want.cnt)};
            if (got.vx !== want.vx) diff = {diff, $sformatf(" vx %h/%h", got.vx, want.vx)};
            if (got.vy !== want.vy) diff = {diff, $sformatf(" vy %h/%h", got.vy, want.vy)};
            if (got.vz !== want.vz) diff = {diff, $sformatf(" vz %h/%h", got.vz, want.vz)};
            if (diff != "")
                report({"centroid (got/want):", diff});
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               func;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic [7:0]         red, green, blue;
    logic [8:0]         bin_index;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               done;
    logic signed [31:0] centroid_x, centroid_y, centroid_z;
    logic [7:0]         mean_red, mean_green, mean_blue;
    logic [15:0]        point_count;
    logic signed [15:0] voxel_x, voxel_y, voxel_z;

    voxel_bin_tracker tracker = new();
    int               stall_cycles = 0;
    logic signed [31:0] hot_x [8];
    logic signed [31:0] hot_y [8];
    logic signed [31:0] hot_z [8];

    hashed_voxel_centroid_downsampler i_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .func(func),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .red(red), .green(green), .blue(blue), .bin_index(bin_index),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .done(done),
        .centroid_x(centroid_x), .centroid_y(centroid_y), .centroid_z(centroid_z),
        .mean_red(mean_red), .mean_green(mean_green), .mean_blue(mean_blue),
        .point_count(point_count), .voxel_x(voxel_x), .voxel_y(voxel_y),
        .voxel_z(voxel_z)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitor: note accepted items and writes, check centroids, watch stalls
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        centroid_t got;
        bit        progress;
        if (rst_n)
        begin
            progress = 1'b0;
            if (start && !busy)
            begin
                tracker.note_item(func, pos_x, pos_y, pos_z, red, green, blue, bin_index);
                progress = 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                tracker.note_config(cfg_index, cfg_data);
                progress = 1'b1;
            end
            if (done)
            begin
                got = '{centroid_x, centroid_y, centroid_z, mean_red, mean_green,
                        mean_blue, point_count, voxel_x, voxel_y, voxel_z};
                tracker.check_centroid(got);
                progress = 1'b1;
            end
            // restart the count on progress, else advance it
            if (progress)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_MAX)
            begin
                $display("timeout: no progress for %0d cycles", STALL_MAX);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // pick a cluster center: mostly near the origin, sometimes anywhere
    function logic signed [31:0] pick_center();
        if ($urandom_range(0, 3) == 0)
            return 32'($urandom);
        return 32'($urandom_range(0, 8'hFF) << 14) - 32'sh200000;
    endfunction

    // hold the item until accepted, then drop start and idle for the gap, if any
    task send_item(logic f, logic signed [31:0] px, logic signed [31:0] py,
                   logic signed [31:0] pz, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                   logic [8:0] bi, int gap);
        func <= f;
        pos_x <= px; pos_y <= py; pos_z <= pz;
        red <= r; green <= g; blue <= b;
        bin_index <= bi;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task send_point(logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] pz,
                    logic [7:0] r, logic [7:0] g, logic [7:0] b);
        send_item(FUNC_ACCUM, px, py, pz, r, g, b, 9'($urandom), pick_gap());
    endtask

    task send_drain(logic [8:0] bi);
        send_item(FUNC_DRAIN, $urandom, $urandom, $urandom,
                  8'($urandom), 8'($urandom), 8'($urandom), bi, pick_gap());
    endtask

    // wait for all centroids, then let a divider run out before touching registers
    task settle();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.pending_centroids.size() != 0 || busy)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // hold the write until accepted, then drop valid for one cycle
    task write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task set_leaf(logic [31:0] ix, logic [31:0] iy, logic [31:0] iz, logic color);
        write_reg(REG_INV_X, ix);
        write_reg(REG_INV_Y, iy);
        write_reg(REG_INV_Z, iz);
        write_reg(REG_COLOR, {31'd0, color});
    endtask

    // clustered points around a few hot centers, some noise and drains
    task random_phase(int count, bit no_idle);
        int kind;
        int c;
        for (int k = 0; k < 8; k++)
        begin
            hot_x[k] = pick_center();
            hot_y[k] = pick_center();
            hot_z[k] = pick_center();
        end
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 99);
            c = $urandom_range(0, 7);
            if (kind < 10)
                send_item(FUNC_DRAIN, $urandom, $urandom, $urandom,
                          8'($urandom), 8'($urandom), 8'($urandom), 9'($urandom),
                          no_idle ? 0 : pick_gap());
            else if (kind < 25)
                send_item(FUNC_ACCUM, $urandom, $urandom, $urandom,
                          8'($urandom), 8'($urandom), 8'($urandom), 9'($urandom),
                          no_idle ? 0 : pick_gap());
            else
                send_item(FUNC_ACCUM, hot_x[c] + 32'($urandom_range(0, 16'hFFFF)),
                          hot_y[c] + 32'($urandom_range(0, 16'hFFFF)),
                          hot_z[c] + 32'($urandom_range(0, 16'hFFFF)),
                          8'($urandom), 8'($urandom), 8'($urandom), 9'($urandom),
                          no_idle ? 0 : pick_gap());
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    localparam logic signed [31:0] POS_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] POS_MIN = 32'sh80000000;
    localparam logic [31:0]        ONE_Q16 = 32'h0001_0000;

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        func = FUNC_ACCUM;
        pos_x = '0; pos_y = '0; pos_z = '0;
        red = '0; green = '0; blue = '0;
        bin_index = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_INV_X;
        cfg_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // hold off until the bin clearing pass is over
        @(posedge clk);
        while (busy)
            @(posedge clk);

        // reset settings: origin, repeats, saturated corners, drains
        send_point(0, 0, 0, 8'hFF, 8'hFF, 8'hFF);
        send_point(0, 0, 0, 8'h00, 8'h00, 8'h00);
        send_point(POS_MAX, POS_MAX, POS_MAX, 8'h12, 8'h34, 8'h56);
        send_point(POS_MIN, POS_MIN, POS_MIN, 8'hAA, 8'h55, 8'hFF);
        send_point(POS_MAX, POS_MIN, 32'sh0000_8000, 8'h01, 8'h80, 8'hFE);
        send_point(POS_MAX - 1, POS_MAX, POS_MAX, 8'h00, 8'h00, 8'h00);
        send_drain(9'd0);
        send_drain(9'd511);
        send_point(32'sh0001_0000, -32'sh0001_0000, 32'sh0000_0001, 8'h10, 8'h20, 8'h30);
        settle();

        // unit leaf, colour on: voxel x and x+512 share bin 3
        set_leaf(ONE_Q16, ONE_Q16, ONE_Q16, 1'b1);
        send_point(32'sh0001_0000, 0, 0, 8'hFF, 8'h00, 8'h7F);
        send_point(32'sh0001_8000, 0, 0, 8'h00, 8'hFF, 8'h80);
        send_point(32'sh0201_0000, 0, 0, 8'hFF, 8'hFF, 8'hFF);
        send_point(-32'sh0000_0001, -32'sh0000_0001, -32'sh0000_0001, 8'h03, 8'h02, 8'h01);
        settle();
        // toggle colour with a bin half filled
        write_reg(REG_COLOR, 32'd0);
        send_point(32'sh0201_4000, 32'sh0000_2000, 0, 8'h40, 8'h40, 8'h40);
        settle();
        write_reg(REG_COLOR, 32'd1);
        send_drain(9'd3);
        send_drain(9'd3);
        settle();
        // zero and full-scale inverse sizes
        set_leaf(32'd0, 32'hFFFF_FFFF, 32'd1, 1'b1);
        send_point(32'($urandom), 32'sh0000_0001, POS_MAX, 8'h80, 8'h81, 8'h82);
        send_point(32'($urandom), -32'sh0000_0001, POS_MIN, 8'h7F, 8'h7E, 8'h7D);
        send_point(32'($urandom), POS_MAX, 0, 8'h11, 8'h22, 8'h33);
        settle();

        // random phases under different leaf settings
        set_leaf(32'd6553600, 32'd6553600, 32'd6553600, 1'b1);
        random_phase(130, 1'b0);
        settle();
        set_leaf(ONE_Q16, ONE_Q16 >> 2, ONE_Q16 << 4, 1'b0);
        random_phase(130, 1'b1);
        settle();
        set_leaf(32'd1, 32'hFFFF_FFFF, 32'($urandom), 1'b1);
        random_phase(130, 1'b0);
        settle();
        set_leaf(32'($urandom), 32'($urandom_range(1, 32'h0010_0000)),
                 32'($urandom_range(1, 32'h0010_0000)), 1'($urandom));
        random_phase(130, 1'b0);
        settle();

        // flush every bin
        for (int k = 0; k < NUM_BINS; k++)
            send_drain(9'(k));
        settle();

        if (tracker.pending_centroids.size() != 0)
            tracker.report($sformatf("%0d centroids never arrived",
                                     tracker.pending_centroids.size()));
        $display("run covered %0d points and %0d drains; %0d centroids compared",
                 tracker.points_seen, tracker.drains_seen, tracker.centroids_seen);
        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: files.f
rtl/hvcd_pkg.sv
rtl/hvcd_ram.sv
rtl/hvcd_divider.sv
rtl/hashed_voxel_centroid_downsampler.sv
tb/hashed_voxel_centroid_downsampler_test.sv
